/* hw/rtl/kced_pkg.sv */
//------------------------------------------------------------------------------
// kced_pkg
// Shared types and constants for the key click event detector.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kced_pkg;

  // Field widths fixed by the interface
  localparam int KEY_W     = 2;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int REG_IDX_W = 2;
  localparam int EVENT_W   = 2;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DOUBLE_CLICK = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd300;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_CLICK  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
  localparam logic [EVENT_W-1:0] EV_LONG   = 2'd3;

  // Per-key gesture state
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PRESS   = 3'd1,
    ST_RELEASE = 3'd2,
    ST_WAIT2   = 3'd3,
    ST_LONG    = 3'd4
  } key_state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_index;
    logic              key_level;
    logic [TIME_W-1:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [EVENT_W-1:0] key_event;
    logic [KEY_W-1:0]   event_key;
  } out_beat_t;

  // One entry of the per-key store
  typedef struct packed {
    logic              prev_level;
    key_state_t        state;
    logic [TIME_W-1:0] press_stamp;
    logic [TIME_W-1:0] release_stamp;
  } key_entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] double_click_ms;
  } timing_cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/kced_state_mem.sv */
//------------------------------------------------------------------------------
// kced_state_mem
// Per-key state store: registered synchronous read, write-to-read
// bypass on the same address, and per-entry valid bits cleared by reset.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kced_state_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output kced_pkg::key_entry_t      rd_entry,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire kced_pkg::key_entry_t wr_entry
);

  kced_pkg::key_entry_t mem [DEPTH];
  logic [DEPTH-1:0]     entry_valid;

  // Storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Valid bits: an unwritten entry reads as the reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read with bypass of a write in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_entry <= wr_entry;
      end else if (entry_valid[rd_addr]) begin
        rd_entry <= mem[rd_addr];
      end else begin
        rd_entry <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/kced_update.sv */
//------------------------------------------------------------------------------
// kced_update
// Gesture state update for one key: next state, new stamps and the event.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kced_update (
  input  wire kced_pkg::key_entry_t               cur,
  input  wire logic                               key_level,
  input  wire logic [kced_pkg::TIME_W-1:0]        now_ms,
  input  wire kced_pkg::timing_cfg_t              cfg,
  output kced_pkg::key_entry_t                    nxt,
  output logic [kced_pkg::EVENT_W-1:0]            key_event
);

  logic                        rise;
  logic                        fall;
  logic [kced_pkg::TIME_W-1:0] dp;
  logic [kced_pkg::TIME_W-1:0] dr;
  logic                        short_press;
  logic                        held_long;
  logic                        gap_over;
  kced_pkg::key_state_t        state_next;

  // Edges and elapsed times (modulo 2^32)
  assign rise        = key_level & ~cur.prev_level;
  assign fall        = ~key_level & cur.prev_level;
  assign dp          = now_ms - cur.press_stamp;
  assign dr          = now_ms - cur.release_stamp;
  assign short_press = dp < {16'd0, cfg.debounce_ms};
  assign held_long   = dp >= {16'd0, cfg.long_press_ms};
  assign gap_over    = dr > {16'd0, cfg.double_click_ms};

  // Next state
  always_comb begin
    state_next = cur.state;
    unique case (cur.state)
      kced_pkg::ST_PRESS: begin
        if (fall) begin
          state_next = short_press ? kced_pkg::ST_IDLE : kced_pkg::ST_RELEASE;
        end else if (key_level && held_long) begin
          state_next = kced_pkg::ST_LONG;
        end
      end
      kced_pkg::ST_RELEASE: begin
        if (gap_over) begin
          state_next = kced_pkg::ST_IDLE;
        end else if (rise) begin
          state_next = kced_pkg::ST_WAIT2;
        end
      end
      kced_pkg::ST_WAIT2: begin
        // early second release stays here
        if (fall) begin
          if (!short_press) state_next = kced_pkg::ST_IDLE;
        end else if (held_long) begin
          state_next = kced_pkg::ST_LONG;
        end
      end
      kced_pkg::ST_LONG: begin
        if (fall) state_next = kced_pkg::ST_IDLE;
      end
      default: begin
        state_next = rise ? kced_pkg::ST_PRESS : kced_pkg::ST_IDLE;
      end
    endcase
  end

  // Event and stamp updates
  always_comb begin
    key_event         = kced_pkg::EV_NONE;
    nxt.prev_level    = key_level;
    nxt.state         = state_next;
    nxt.press_stamp   = cur.press_stamp;
    nxt.release_stamp = cur.release_stamp;
    unique case (cur.state)
      kced_pkg::ST_PRESS: begin
        if (fall) begin
          if (!short_press) nxt.release_stamp = now_ms;
        end else if (key_level && held_long) begin
          key_event = kced_pkg::EV_LONG;
        end
      end
      kced_pkg::ST_RELEASE: begin
        if (gap_over) begin
          key_event = kced_pkg::EV_CLICK;
        end else if (rise) begin
          nxt.press_stamp = now_ms;
        end
      end
      kced_pkg::ST_WAIT2: begin
        if (fall) begin
          if (!short_press) key_event = kced_pkg::EV_DOUBLE;
        end else if (held_long) begin
          key_event = kced_pkg::EV_LONG;
        end
      end
      kced_pkg::ST_LONG: begin
        key_event = kced_pkg::EV_NONE;
      end
      default: begin
        if (rise) nxt.press_stamp = now_ms;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/key_click_event_detector.sv */
//------------------------------------------------------------------------------
// key_click_event_detector
// Click, double click and long press detection on polled key samples, with
// per-key state held in a small read-modify-write store.
//------------------------------------------------------------------------------
//  Channel  | Signals                          | Beat
//  ---------+----------------------------------+------------------------------
//  in       | in_valid, in_stall, in_data      | key_index, key_level, now_ms
//  out      | out_valid, out_stall, out_data   | key_event, event_key
//  cfg      | cfg_we, cfg_index, cfg_data      | one timing register write
//
//  One sample per clock while the output is not stalled; the store read and
//  the beat capture are registered on acceptance, and the update is then
//  registered into the output register.
//  A sample on the key just updated reads the bypassed write data.
//  Reset clears the per-key valid bits at once; no clearing pass.
//  A stalled output beat holds the update stage; the input stalls whenever
//  that stage is full as well.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_click_event_detector #(
  parameter int NUM_KEYS = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire kced_pkg::in_beat_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output kced_pkg::out_beat_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [kced_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire logic [kced_pkg::CFG_W-1:0]          cfg_data
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  kced_pkg::timing_cfg_t cfg;
  kced_pkg::in_beat_t    s1_beat;
  logic                  s1_valid;
  logic                  s1_in_range;
  logic                  advance;
  logic                  accept;
  logic                  wr_en;
  kced_pkg::key_entry_t  rd_entry;
  kced_pkg::key_entry_t  upd_entry;
  logic [kced_pkg::EVENT_W-1:0] upd_event;

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= kced_pkg::DEBOUNCE_RST;
      cfg.long_press_ms   <= kced_pkg::LONG_PRESS_RST;
      cfg.double_click_ms <= kced_pkg::DOUBLE_CLICK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kced_pkg::REG_DEBOUNCE:     cfg.debounce_ms     <= cfg_data;
        kced_pkg::REG_LONG_PRESS:   cfg.long_press_ms   <= cfg_data;
        kced_pkg::REG_DOUBLE_CLICK: cfg.double_click_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake
  assign advance  = ~out_valid | ~out_stall;
  assign in_stall = rst | (s1_valid & ~advance);
  assign accept   = in_valid & ~in_stall;

  // Update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_beat <= in_data;
  end

  assign s1_in_range = int'(s1_beat.key_index) < NUM_KEYS;
  assign wr_en       = s1_valid & advance & s1_in_range;

  kced_state_mem #(
    .DEPTH (NUM_KEYS),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (AW'(in_data.key_index)),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (AW'(s1_beat.key_index)),
    .wr_entry (upd_entry)
  );

  kced_update u_update (
    .cur       (rd_entry),
    .key_level (s1_beat.key_level),
    .now_ms    (s1_beat.now_ms),
    .cfg       (cfg),
    .nxt       (upd_entry),
    .key_event (upd_event)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_data.key_event <= s1_in_range ? upd_event : kced_pkg::EV_NONE;
      out_data.event_key <= s1_beat.key_index;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/kced_checker.sv */
//------------------------------------------------------------------------------
// kced_checker
// Port-level checks for the key click event detector, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kced_checker #(
  parameter int NUM_KEYS = 4
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire kced_pkg::out_beat_t out_data
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // With the output register empty the input is never stalled
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  // A key beyond the configured count never raises an event
  a_oob_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (int'(out_data.event_key) >= NUM_KEYS)
      |-> out_data.key_event == kced_pkg::EV_NONE)
    else $error("event raised for a key beyond the key count");

endmodule

bind key_click_event_detector kced_checker #(
  .NUM_KEYS (NUM_KEYS)
) u_kced_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
